/* rtl/trxf_pkg.sv */
// ----------------------------------------------------------------------------
// trxf_pkg: shared types and constants for the telnet receive filter
// Byte codes, parser states, result kinds and the bundles passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package trxf_pkg;

    // Telnet and console byte codes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_ESC  = 8'h1b;
    localparam logic [7:0] B_GT   = 8'h3e;
    localparam logic [7:0] B_CR   = 8'h0d;
    localparam logic [7:0] B_LF   = 8'h0a;
    localparam logic [7:0] B_NUL  = 8'h00;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_RESET = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_IAC    = 3'd1,
        ST_OPT    = 3'd2,
        ST_SUB    = 3'd3,
        ST_SUBIAC = 3'd4
    } parse_state_t;

    typedef enum logic [1:0] {
        KIND_CONSOLE = 2'd0,
        KIND_SHELL   = 2'd1,
        KIND_ENTRY   = 2'd2
    } kind_t;

    // Escape prefix progress codes
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_TWO  = 2'd2;

    typedef struct packed {
        func_t      func;
        logic [7:0] rx_byte;
        logic       shell_active;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last;
    } res_t;

    // Up to three results produced by one item
    typedef struct packed {
        logic [1:0] cnt;
        res_t [2:0] res;
    } res_group_t;

endpackage

`default_nettype wire

/* rtl/trxf_in_stage.sv */
// ----------------------------------------------------------------------------
// trxf_in_stage: input register
// Captures one item per cycle unless the held item still waits for commit; frees itself when the item is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module trxf_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire trxf_pkg::item_t in_item,
    input  wire logic           commit,
    output logic                item_valid,
    output trxf_pkg::item_t     item
);

    logic            valid_reg;
    trxf_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || commit;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/trxf_core.sv */
// ----------------------------------------------------------------------------
// trxf_core: telnet parser and escape detector
// Holds filter state and timeout register; builds the result group for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module trxf_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_data,
    input  wire trxf_pkg::item_t       item,
    input  wire logic                  commit,
    output trxf_pkg::res_group_t       group
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    trxf_pkg::parse_state_t parse_reg, parse_next;
    logic                   after_cr_reg, after_cr_next;
    logic [1:0]             prog_reg, prog_next;
    logic [TIMER_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [15:0]            timeout_reg;

    logic       route_en;
    logic [1:0] cnt;
    trxf_pkg::kind_t [2:0] r_kind;
    logic [2:0][7:0]       r_byte;

    // Parser: next state and which byte is routed
    always_comb
    begin
        parse_next    = parse_reg;
        after_cr_next = after_cr_reg;
        route_en      = 1'b0;
        if (item.func == trxf_pkg::FUNC_BYTE)
        begin
            unique case (parse_reg)
                trxf_pkg::ST_IAC:
                begin
                    if (item.rx_byte == trxf_pkg::B_IAC)
                    begin
                        route_en   = 1'b1;
                        parse_next = trxf_pkg::ST_DATA;
                    end
                    else if (item.rx_byte == trxf_pkg::B_SB)
                    begin
                        parse_next = trxf_pkg::ST_SUB;
                    end
                    else if (item.rx_byte == trxf_pkg::B_WILL || item.rx_byte == trxf_pkg::B_WONT
                          || item.rx_byte == trxf_pkg::B_DO || item.rx_byte == trxf_pkg::B_DONT)
                    begin
                        parse_next = trxf_pkg::ST_OPT;
                    end
                    else
                    begin
                        parse_next = trxf_pkg::ST_DATA;
                    end
                end
                trxf_pkg::ST_OPT:
                begin
                    parse_next = trxf_pkg::ST_DATA;
                end
                trxf_pkg::ST_SUB:
                begin
                    if (item.rx_byte == trxf_pkg::B_IAC)
                    begin
                        parse_next = trxf_pkg::ST_SUBIAC;
                    end
                end
                trxf_pkg::ST_SUBIAC:
                begin
                    parse_next = (item.rx_byte == trxf_pkg::B_SE) ? trxf_pkg::ST_DATA
                                                                  : trxf_pkg::ST_SUB;
                end
                default:
                begin
                    parse_next = trxf_pkg::ST_DATA;
                    if (item.rx_byte == trxf_pkg::B_IAC)
                    begin
                        parse_next = trxf_pkg::ST_IAC;
                    end
                    else if (after_cr_reg && (item.rx_byte == trxf_pkg::B_NUL
                                           || item.rx_byte == trxf_pkg::B_LF))
                    begin
                        after_cr_next = 1'b0;
                    end
                    else
                    begin
                        route_en      = 1'b1;
                        after_cr_next = (item.rx_byte == trxf_pkg::B_CR);
                    end
                end
            endcase
        end
        else if (item.func == trxf_pkg::FUNC_RESET)
        begin
            parse_next    = trxf_pkg::ST_DATA;
            after_cr_next = 1'b0;
        end
    end

    // Escape detection, tick timer and result list
    always_comb
    begin
        logic                  pass;
        logic [TIMER_BITS-1:0] inc;
        prog_next    = prog_reg;
        elapsed_next = elapsed_reg;
        cnt          = 2'd0;
        r_kind       = {3{trxf_pkg::KIND_CONSOLE}};
        r_byte       = '0;
        pass         = 1'b0;
        inc          = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        if (item.func == trxf_pkg::FUNC_BYTE && route_en)
        begin
            if (item.shell_active)
            begin
                r_kind[cnt] = trxf_pkg::KIND_SHELL;
                r_byte[cnt] = (item.rx_byte == trxf_pkg::B_LF) ? trxf_pkg::B_CR : item.rx_byte;
                cnt         = cnt + 2'd1;
            end
            else
            begin
                pass = 1'b1;
                if (prog_reg == trxf_pkg::ESC_ONE)
                begin
                    elapsed_next = '0;
                    if (item.rx_byte == trxf_pkg::B_GT)
                    begin
                        prog_next = trxf_pkg::ESC_TWO;
                        pass      = 1'b0;
                    end
                    else
                    begin
                        r_byte[cnt] = trxf_pkg::B_ESC;
                        cnt         = cnt + 2'd1;
                        prog_next   = trxf_pkg::ESC_NONE;
                    end
                end
                else if (prog_reg != trxf_pkg::ESC_NONE)
                begin
                    elapsed_next = '0;
                    prog_next    = trxf_pkg::ESC_NONE;
                    if (item.rx_byte == trxf_pkg::B_GT)
                    begin
                        r_kind[cnt] = trxf_pkg::KIND_ENTRY;
                        cnt         = cnt + 2'd1;
                        pass        = 1'b0;
                    end
                    else
                    begin
                        r_byte[cnt] = trxf_pkg::B_ESC;
                        cnt         = cnt + 2'd1;
                        r_byte[cnt] = trxf_pkg::B_GT;
                        cnt         = cnt + 2'd1;
                    end
                end
                if (pass)
                begin
                    if (item.rx_byte == trxf_pkg::B_ESC)
                    begin
                        prog_next    = trxf_pkg::ESC_ONE;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        r_byte[cnt] = item.rx_byte;
                        cnt         = cnt + 2'd1;
                    end
                end
            end
        end
        else if (item.func == trxf_pkg::FUNC_TICK && prog_reg != trxf_pkg::ESC_NONE)
        begin
            if (CMP_W'(inc) >= CMP_W'(timeout_reg))
            begin
                r_byte[cnt] = trxf_pkg::B_ESC;
                cnt         = cnt + 2'd1;
                if (prog_reg != trxf_pkg::ESC_ONE)
                begin
                    r_byte[cnt] = trxf_pkg::B_GT;
                    cnt         = cnt + 2'd1;
                end
                prog_next    = trxf_pkg::ESC_NONE;
                elapsed_next = '0;
            end
            else
            begin
                elapsed_next = inc;
            end
        end
        else if (item.func == trxf_pkg::FUNC_RESET)
        begin
            prog_next    = trxf_pkg::ESC_NONE;
            elapsed_next = '0;
        end
    end

    always_comb
    begin
        group.cnt = cnt;
        for (int i = 0; i < 3; i++)
        begin
            group.res[i].kind     = r_kind[i];
            group.res[i].out_byte = r_byte[i];
            group.res[i].last     = (2'(i) == cnt - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg    <= trxf_pkg::ST_DATA;
            after_cr_reg <= 1'b0;
            prog_reg     <= trxf_pkg::ESC_NONE;
            elapsed_reg  <= '0;
            timeout_reg  <= trxf_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (commit)
            begin
                parse_reg    <= parse_next;
                after_cr_reg <= after_cr_next;
                prog_reg     <= prog_next;
                elapsed_reg  <= elapsed_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/trxf_out_buf.sv */
// ----------------------------------------------------------------------------
// trxf_out_buf: result register
// Loads the results of one item and hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module trxf_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire trxf_pkg::res_group_t group,
    input  wire logic                 load,
    output logic                      load_ok,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output trxf_pkg::res_t            out_res
);

    logic [1:0]                cnt_reg;
    trxf_pkg::res_t [2:0]      buf_reg;
    logic                      pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = buf_reg[0];
    assign pop       = out_valid && out_ready;
    // Free when empty or when the final held result leaves this cycle
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= group.cnt;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= group.res;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

endmodule

`default_nettype wire

/* rtl/telnet_rx_filter_escape_detect_top.sv */
// Path: each item passes through the input register and then the result register.
// Throughput: one item per cycle while the result register is free; an item with n
//   results (n up to 3) holds the result register until all n have left through the single output port.
// Reset: rst_n clears parser, escape state and buffers; timeout returns to 5000.
// ----------------------------------------------------------------------------
// telnet_rx_filter_escape_detect_top: telnet receive filter with escape detect
// Strips telnet commands, folds CR NUL / CR LF, and detects the ESC > > prefix outside shell mode.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_rx_filter_escape_detect_top #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,   // escape_timeout_ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [7:0] rx_byte, [8] shell_active, rest zero
    input  wire logic [1:0]  s_tuser,    // [1:0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic [1:0]       m_tuser,    // [1:0] kind
    output logic             m_tlast
);

    trxf_pkg::item_t      in_item;
    trxf_pkg::item_t      item;
    trxf_pkg::res_group_t group;
    trxf_pkg::res_t       out_res;
    logic                 item_valid;
    logic                 load_ok;
    logic                 commit;

    assign cfg_ready = 1'b1;

    assign in_item.func         = trxf_pkg::func_t'(s_tuser);
    assign in_item.rx_byte      = s_tdata[7:0];
    assign in_item.shell_active = s_tdata[8];

    assign commit = item_valid && load_ok;

    trxf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .commit     (commit),
        .item_valid (item_valid),
        .item       (item)
    );

    trxf_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .item     (item),
        .commit   (commit),
        .group    (group)
    );

    trxf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .group     (group),
        .load      (commit),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire
